// ===== sv/sdtq_pkg.sv =====
// Shared types and constants for the sorted deadline timer queue.
`default_nettype none
package sdtq_pkg;

	localparam int DEPTH     = 16;
	localparam int SLOT_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int TAG_W     = 32;
	localparam int TIME_W    = 64;
	localparam int DELAY_W   = 31;
	localparam int US_PER_MS = 1000;
	localparam int SCALE_W   = $clog2(US_PER_MS + 1);
	localparam int PROD_W    = DELAY_W + SCALE_W;

	typedef enum logic [1:0] {
		FUNC_ADD        = 2'd0,
		FUNC_DEL_HANDLE = 2'd1,
		FUNC_DEL_TAG    = 2'd2,
		FUNC_CHECK      = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FIRED   = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_ADD,
		RES_HIT
	} res_src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_MUL,
		S_ADD_SUM,
		S_ADD_SCAN,
		S_ADD_INS,
		S_DEL_SCAN,
		S_CHK_TEST,
		S_CHK_FIRE,
		S_WAIT_CALC,
		S_FINAL
	} state_t;

	typedef struct packed {
		func_t                func;
		logic [TIME_W-1:0]    now_us;
		logic [DELAY_W-1:0]   delay_ms;
		logic [SLOT_W-1:0]    handle;
		logic [TAG_W-1:0]     client_tag;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [SLOT_W-1:0]    slot_id;
		logic [TAG_W-1:0]     fired_tag;
		logic                 pending;
		logic [TIME_W-1:0]    wait_us;
		logic                 last;
	} rsp_t;

	typedef struct packed {
		logic     capture;
		logic     mul;
		logic     sum;
		logic     idx_inc;
		logic     insert;
		logic     remove;
		logic     res_set;
		res_src_t res_src;
		status_t  res_code;
		logic     calc_wait;
		logic     out_fire;
		logic     out_final;
	} dp_cmd_t;

	typedef struct packed {
		logic             full;
		logic             scan_end;
		logic             scan_lt;
		logic             hit;
		logic             head_expired;
		logic             out_free;
		logic [CNT_W-1:0] count;
		logic [DEPTH-1:0] busy;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== sv/sorted_deadline_timer_queue.sv =====
// Top level: sorted deadline timer queue, controller plus datapath.
// Add walks the entries with an earlier deadline, one per cycle, before inserting; a full
// table gives FULL without a scan. Delete scans the list up to the match; check fires the
// expired timers before its final result. One transaction at a time: req_stall is high
// until the final result is loaded, and the next one is taken in the following cycle.
// Reset: arst_n clears the entry count, slot map, state and output valid; stores are
// written before they are read.
`default_nettype none
module sorted_deadline_timer_queue
	import sdtq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	dp_cmd_t    cmd;
	dp_status_t status;

	sdtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_func  (req.func),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	sdtq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FIRED |-> !rsp.last)
		else $error("fired result marked last");

	a_empty_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last && !rsp.pending |-> rsp.wait_us == '0)
		else $error("nonzero wait with empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.count <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_busy_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(status.busy) == int'(status.count))
		else $error("slot map out of step with entry count");

endmodule
`default_nettype wire

// ===== sv/sdtq_datapath.sv =====
// Datapath: timer stores, ordered slot list, deadline arithmetic and result register.
`default_nettype none
module sdtq_datapath
	import sdtq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	output dp_status_t      status,
	input  wire req_t       req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rsp_t            rsp
);

	function automatic logic [SLOT_W-1:0] lowest_free(input logic [DEPTH-1:0] busy);
		logic [SLOT_W-1:0] s;
		s = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!busy[i]) s = SLOT_W'(i);
		end
		return s;
	endfunction

	// latched transaction
	func_t               func_q;
	logic [TIME_W-1:0]   now_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [SLOT_W-1:0]   handle_q;
	logic [TAG_W-1:0]    tag_in_q;

	logic [PROD_W-1:0]   prod_q;
	logic [TIME_W-1:0]   dl_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    idx_q;
	status_t             res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [TAG_W-1:0]    res_tag_q;
	logic [TIME_W-1:0]   wait_q;

	logic [TIME_W-1:0]   deadline_q [DEPTH];
	logic [TAG_W-1:0]    tag_store_q [DEPTH];
	logic [SLOT_W-1:0]   order_q [DEPTH];
	logic [CNT_W-1:0]    count_q;
	logic [DEPTH-1:0]    busy_q;

	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic [SLOT_W-1:0]   rd_slot;
	logic [TIME_W-1:0]   rd_deadline;
	logic [TAG_W-1:0]    rd_tag;
	logic [TIME_W:0]     dl_sum;

	// single read port: the list entry at the scan index
	assign rd_slot     = order_q[idx_q[SLOT_W-1:0]];
	assign rd_deadline = deadline_q[rd_slot];
	assign rd_tag      = tag_store_q[rd_slot];
	assign dl_sum      = {1'b0, now_q} + {{(TIME_W + 1 - PROD_W){1'b0}}, prod_q};

	always_comb begin
		status.full         = (count_q == CNT_W'(DEPTH));
		status.scan_end     = (idx_q == count_q);
		status.scan_lt      = (rd_deadline < dl_q);
		status.hit          = (func_q == FUNC_DEL_HANDLE) ? (rd_slot == handle_q)
		                      : ((tag_in_q != '0) && (rd_tag == tag_in_q));
		status.head_expired = (count_q != '0) && (rd_deadline < now_q);
		status.out_free     = !rsp_valid_q || !rsp_stall;
		status.count        = count_q;
		status.busy         = busy_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= req.func;
			now_q    <= req.now_us;
			delay_q  <= req.delay_ms;
			handle_q <= req.handle;
			tag_in_q <= req.client_tag;
		end
		if (cmd.mul)
			prod_q <= PROD_W'(delay_q) * PROD_W'(US_PER_MS);
		if (cmd.sum) begin
			// saturate on overflow
			dl_q   <= dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
			slot_q <= lowest_free(busy_q);
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_code;
			case (cmd.res_src)
				RES_ADD: begin
					res_slot_q <= slot_q;
					res_tag_q  <= tag_in_q;
				end
				RES_HIT: begin
					res_slot_q <= rd_slot;
					res_tag_q  <= rd_tag;
				end
				default: begin
					res_slot_q <= '0;
					res_tag_q  <= '0;
				end
			endcase
		end
		if (cmd.calc_wait)
			wait_q <= (count_q != '0 && rd_deadline > now_q) ? rd_deadline - now_q : '0;
		if (cmd.insert) begin
			deadline_q[slot_q]  <= dl_q;
			tag_store_q[slot_q] <= tag_in_q;
		end
	end

	// ordered slot list: shift open for insert, close up for remove
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int i = 1; i < DEPTH; i++) begin
				if (CNT_W'(i) > idx_q && CNT_W'(i) <= count_q)
					order_q[i] <= order_q[i-1];
			end
			order_q[idx_q[SLOT_W-1:0]] <= slot_q;
		end else if (cmd.remove) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				if (CNT_W'(i) >= idx_q)
					order_q[i] <= order_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
			busy_q  <= '0;
		end else begin
			if (cmd.capture || cmd.res_set)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + CNT_W'(1);
			if (cmd.insert) begin
				busy_q[slot_q] <= 1'b1;
				count_q        <= count_q + CNT_W'(1);
			end else if (cmd.remove) begin
				busy_q[rd_slot] <= 1'b0;
				count_q         <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_fire) begin
			rsp_q.status    <= ST_FIRED;
			rsp_q.slot_id   <= rd_slot;
			rsp_q.fired_tag <= rd_tag;
			rsp_q.pending   <= (count_q > CNT_W'(1));
			rsp_q.wait_us   <= '0;
			rsp_q.last      <= 1'b0;
		end else if (cmd.out_final) begin
			rsp_q.status    <= res_status_q;
			rsp_q.slot_id   <= res_slot_q;
			rsp_q.fired_tag <= res_tag_q;
			rsp_q.pending   <= (count_q != '0);
			rsp_q.wait_us   <= wait_q;
			rsp_q.last      <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_fire || cmd.out_final) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ===== sv/sdtq_ctrl.sv =====
// Controller state machine: sequences add, delete and check transactions.
`default_nettype none
module sdtq_ctrl
	import sdtq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire func_t      req_func,
	output logic            req_stall,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req_func)
						FUNC_ADD:                     state_d = S_ADD_MUL;
						FUNC_DEL_HANDLE, FUNC_DEL_TAG: state_d = S_DEL_SCAN;
						default:                      state_d = S_CHK_TEST;
					endcase
				end
			end
			S_ADD_MUL:  state_d = status.full ? S_WAIT_CALC : S_ADD_SUM;
			S_ADD_SUM:  state_d = S_ADD_SCAN;
			S_ADD_SCAN: begin
				if (status.scan_end || !status.scan_lt) state_d = S_ADD_INS;
			end
			S_ADD_INS:  state_d = S_WAIT_CALC;
			S_DEL_SCAN: begin
				if (status.scan_end || status.hit) state_d = S_WAIT_CALC;
			end
			S_CHK_TEST: state_d = status.head_expired ? S_CHK_FIRE : S_WAIT_CALC;
			S_CHK_FIRE: begin
				if (status.out_free) state_d = S_CHK_TEST;
			end
			S_WAIT_CALC: state_d = S_FINAL;
			S_FINAL: begin
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.res_src  = RES_ZERO;
		cmd.res_code = ST_DONE;
		req_stall    = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: cmd.capture = req_valid;
			S_ADD_MUL: begin
				cmd.mul = 1'b1;
				if (status.full) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_FULL;
				end
			end
			S_ADD_SUM: cmd.sum = 1'b1;
			S_ADD_SCAN: begin
				if (!status.scan_end && status.scan_lt) cmd.idx_inc = 1'b1;
			end
			S_ADD_INS: begin
				cmd.insert  = 1'b1;
				cmd.res_set = 1'b1;
				cmd.res_src = RES_ADD;
			end
			S_DEL_SCAN: begin
				if (status.scan_end) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_NOMATCH;
				end else if (status.hit) begin
					cmd.remove  = 1'b1;
					cmd.res_set = 1'b1;
					cmd.res_src = RES_HIT;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_CHK_TEST: begin
				if (!status.head_expired) cmd.res_set = 1'b1;
			end
			S_CHK_FIRE: begin
				// emit and pop the head together
				if (status.out_free) begin
					cmd.out_fire = 1'b1;
					cmd.remove   = 1'b1;
				end
			end
			S_WAIT_CALC: cmd.calc_wait = 1'b1;
			S_FINAL:     cmd.out_final = status.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire
